// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// Needs nothing else; the caller supplies clock, reset and property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An overlapping implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A next-cycle implication checked at every rising clock edge outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rse_pkg.sv =====
// Package for the RPN stack evaluator: token and status codes, widths,
// defaults and the 32-bit saturation helper. Depends on nothing.
`default_nettype none

package rse_pkg;

   localparam int DATA_W        = 32;
   localparam int PROD_W        = 64;
   localparam int DIV_W         = 64;
   localparam int DEFAULT_DEPTH = 128;
   localparam int DEFAULT_FRAC  = 16;

   localparam logic [2:0] TOK_NUM   = 3'd0;
   localparam logic [2:0] TOK_ADD   = 3'd1;
   localparam logic [2:0] TOK_SUB   = 3'd2;
   localparam logic [2:0] TOK_MUL   = 3'd3;
   localparam logic [2:0] TOK_DIV   = 3'd4;
   localparam logic [2:0] TOK_REM   = 3'd5;
   localparam logic [2:0] TOK_PRINT = 3'd6;
   localparam logic [2:0] TOK_UNK   = 3'd7;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_EMPTY   = 3'd2;
   localparam logic [2:0] ST_ZDIV    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_SAT     = 3'd5;

   localparam logic signed [PROD_W-1:0] Q_MAX = 64'sd2147483647;
   localparam logic signed [PROD_W-1:0] Q_MIN = -64'sd2147483648;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] val;
   } sat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_ctl_type;

   function automatic sat_type sat32(input logic signed [PROD_W-1:0] v);
      sat_type s;
      if (v > Q_MAX) begin
         s.hit = 1'b1;
         s.val = Q_MAX[DATA_W-1:0];
      end else if (v < Q_MIN) begin
         s.hit = 1'b1;
         s.val = Q_MIN[DATA_W-1:0];
      end else begin
         s.hit = 1'b0;
         s.val = v[DATA_W-1:0];
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rpn_stack_evaluator.sv =====
// Top level of the RPN stack evaluator: token sequencer, stack RAM and divider.
// Depends on rse_pkg, rse_stack and rse_div.
//
// Usage. Tokens arrive on the req_ stream: req_tuser carries the token kind
// and req_tdata the Q16.16 number for a push. Every token gives exactly one
// transfer on the rsp_ stream: rsp_tdata holds the printed value (zero unless
// printed), rsp_tuser bit 0 the printed flag and bits 3:1 the status code.
// One token is worked on at a time; req_tready is high only while the
// sequencer is idle. The stack RAM has one read port, so the two operands
// are read one after the other; the divider produces one quotient bit per
// cycle over 64 steps. The result sits in an output register. A stalled
// receiver holds the token in its last cycle until that register is free; a
// token accepted meanwhile is already being popped. Reset clears the stack
// count, the sequencer and the output valid; the stack RAM is not cleared,
// since only entries below the count are ever used.
`default_nettype none

module rpn_stack_evaluator
   import rse_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_DEPTH,
   parameter int FRAC_BITS   = DEFAULT_FRAC
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [31:0] operand_value
   input  wire logic [2:0]  req_tuser,  // [2:0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // [31:0] result_value
   output logic      [3:0]  rsp_tuser   // [0] printed, [3:1] status
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POPB = 3'd1;
   localparam logic [2:0] S_POPA = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_RSP  = 3'd5;

   logic [2:0]               state_ff;
   logic [2:0]               op_ff;
   logic [DATA_W-1:0]        num_ff;
   logic [CW-1:0]            count_ff;
   logic                     emp_ff, sat_ff, zdiv_ff, push_ff;
   logic [DATA_W-1:0]        res_ff, shown_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     qneg_ff, aneg_ff;
   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        rsp_data_ff;
   logic [3:0]               rsp_user_ff;

   logic [AW-1:0]            rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic                     wr_en;
   logic                     cnt_zero, is_full, load_rsp, do_pop;
   logic [DATA_W-1:0]        pop_val, a_mag, b_mag;
   logic signed [PROD_W-1:0] add_sum, sub_dif, mul_shift, q_signed;
   logic [DIV_W-1:0]         div_dvd;
   logic                     div_start;
   div_ctl_type              div_ctl;
   logic [DIV_W-1:0]         div_quot;
   logic [DATA_W-1:0]        div_rem;
   sat_type                  sat_add, sat_sub, sat_mul, sat_div;
   logic [2:0]               status;

   assign cnt_zero  = (count_ff == '0);
   assign is_full   = (count_ff == CW'(STACK_DEPTH));
   assign pop_val   = cnt_zero ? '0 : rd_data;
   assign load_rsp  = (state_ff == S_RSP) && (!rsp_valid_ff || rsp_tready);
   assign wr_en     = load_rsp && push_ff && !is_full;
   assign do_pop    = (op_ff != TOK_NUM) && (op_ff != TOK_UNK);
   assign div_start = (state_ff == S_POPA) && ((op_ff == TOK_DIV) || (op_ff == TOK_REM));

   // The top entry is read while idle, the one below it during the first pop.
   assign rd_addr = (state_ff == S_POPB) ? AW'(count_ff - CW'(2)) : AW'(count_ff - CW'(1));

   // Operands: b lives in res_ff after the first pop; a comes from the RAM.
   always_comb begin
      a_mag     = pop_val[DATA_W-1] ? DATA_W'(-pop_val) : pop_val;
      b_mag     = res_ff[DATA_W-1] ? DATA_W'(-res_ff) : res_ff;
      add_sum   = PROD_W'($signed(pop_val)) + PROD_W'($signed(res_ff));
      sub_dif   = PROD_W'($signed(pop_val)) - PROD_W'($signed(res_ff));
      mul_shift = prod_ff >>> FRAC_BITS;
      q_signed  = qneg_ff ? -$signed(div_quot) : $signed(div_quot);
      sat_add   = sat32(add_sum);
      sat_sub   = sat32(sub_dif);
      sat_mul   = sat32(mul_shift);
      sat_div   = sat32(q_signed);
      if (op_ff == TOK_DIV) begin
         div_dvd = DIV_W'(a_mag) << FRAC_BITS;
      end else begin
         div_dvd = DIV_W'(a_mag);
      end
   end

   always_comb begin
      priority if (zdiv_ff) begin
         status = ST_ZDIV;
      end else if (op_ff == TOK_UNK) begin
         status = ST_UNKNOWN;
      end else if (push_ff && is_full) begin
         status = ST_FULL;
      end else if (emp_ff) begin
         status = ST_EMPTY;
      end else if (sat_ff) begin
         status = ST_SAT;
      end else begin
         status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_POPB;
               end
            end
            S_POPB: begin
               if (do_pop && !cnt_zero) begin
                  count_ff <= count_ff - CW'(1);
               end
               if ((op_ff == TOK_ADD) || (op_ff == TOK_SUB) || (op_ff == TOK_MUL)) begin
                  state_ff <= S_POPA;
               end else if (((op_ff == TOK_DIV) || (op_ff == TOK_REM)) && (pop_val != '0)) begin
                  state_ff <= S_POPA;
               end else begin
                  state_ff <= S_RSP;
               end
            end
            S_POPA: begin
               if (!cnt_zero) begin
                  count_ff <= count_ff - CW'(1);
               end
               if (op_ff == TOK_MUL) begin
                  state_ff <= S_MUL;
               end else if ((op_ff == TOK_DIV) || (op_ff == TOK_REM)) begin
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_RSP;
               end
            end
            S_MUL: begin
               state_ff <= S_RSP;
            end
            S_DIV: begin
               if (div_ctl.done) begin
                  state_ff <= S_RSP;
               end
            end
            S_RSP: begin
               if (load_rsp) begin
                  if (wr_en) begin
                     count_ff <= count_ff + CW'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Token payload and working values.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            op_ff    <= req_tuser;
            num_ff   <= req_tdata;
            emp_ff   <= 1'b0;
            sat_ff   <= 1'b0;
            zdiv_ff  <= 1'b0;
            push_ff  <= 1'b0;
            shown_ff <= '0;
         end
         S_POPB: begin
            if (do_pop && cnt_zero) begin
               emp_ff <= 1'b1;
            end
            if (op_ff == TOK_NUM) begin
               push_ff <= 1'b1;
               res_ff  <= num_ff;
            end else begin
               res_ff  <= pop_val;
            end
            if (op_ff == TOK_PRINT) begin
               shown_ff <= pop_val;
            end
            if (((op_ff == TOK_DIV) || (op_ff == TOK_REM)) && (pop_val == '0)) begin
               zdiv_ff <= 1'b1;
            end
         end
         S_POPA: begin
            push_ff <= 1'b1;
            if (cnt_zero) begin
               emp_ff <= 1'b1;
            end
            prod_ff <= $signed(pop_val) * $signed(res_ff);
            qneg_ff <= pop_val[DATA_W-1] ^ res_ff[DATA_W-1];
            aneg_ff <= pop_val[DATA_W-1];
            if (op_ff == TOK_ADD) begin
               res_ff <= sat_add.val;
               sat_ff <= sat_add.hit;
            end else if (op_ff == TOK_SUB) begin
               res_ff <= sat_sub.val;
               sat_ff <= sat_sub.hit;
            end
         end
         S_MUL: begin
            res_ff <= sat_mul.val;
            sat_ff <= sat_mul.hit;
         end
         S_DIV: begin
            if (div_ctl.done) begin
               if (op_ff == TOK_DIV) begin
                  res_ff <= sat_div.val;
                  sat_ff <= sat_div.hit;
               end else begin
                  res_ff <= aneg_ff ? DATA_W'(-div_rem) : div_rem;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= shown_ff;
         rsp_user_ff <= {status, (op_ff == TOK_PRINT)};
      end
   end

   rse_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(res_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   rse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (b_mag),
      .ctl      (div_ctl),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== rtl/rse_stack.sv =====
// Value stack storage: one synchronous RAM, one write and one read port.
// Read data is registered. Uses rse_pkg for the data width.
`default_nettype none

module rse_stack
   import rse_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_DEPTH,
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/rse_div.sv =====
// Restoring divider on magnitudes, one quotient bit per cycle.
// 64-bit dividend, 32-bit divisor. Uses rse_pkg for widths and types.
`default_nettype none

module rse_div
   import rse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output div_ctl_type            ctl,
   output logic      [DIV_W-1:0]  quotient,
   output logic      [DATA_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DATA_W-1:0] dsr_ff;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, done_ff;
   logic [DATA_W:0]   rsh, diff;
   logic              ge;

   always_comb begin
      rsh    = {rem_ff, dvd_ff[DIV_W-1]};
      diff   = rsh - {1'b0, dsr_ff};
      ge     = (rsh >= {1'b0, dsr_ff});
      rem_in = ge ? diff[DATA_W-1:0] : rsh[DATA_W-1:0];
      dvd_in = {dvd_ff[DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/rse_checker.sv =====
// Port-level checker for the RPN stack evaluator, bound to the top level.
// Depends on assert_macros.svh and rse_pkg.
`default_nettype none
`include "assert_macros.svh"

module rse_checker
   import rse_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic [2:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser
);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")
   `CHK_IMPLY(a_status_code, clock, reset, rsp_tvalid, rsp_tuser[3:1] <= ST_SAT, "status code out of range")
   `CHK_IMPLY(a_zero_unprinted, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0, "value on a result that prints nothing")
   `CHK_NEXT(a_one_token, clock, reset, req_tvalid && req_tready, !req_tready, "second token taken while one is at work")

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the RPN stack evaluator: drives tokens on the
// request stream and checks every response against its own stack model.
// Depends on rse_pkg and the rpn_stack_evaluator RTL.
`default_nettype none

module tb;
   import rse_pkg::*;

   localparam int DEPTH     = DEFAULT_DEPTH;
   localparam int FRAC      = DEFAULT_FRAC;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 485;

   typedef struct packed {
      logic [31:0] value;
      logic        printed;
      logic [2:0]  status;
   } resp_type;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] operand;
      logic        has_exp;
      resp_type    exp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] operand_value
   logic [2:0]  req_tuser = '0;   // [2:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] result_value
   logic [3:0]  rsp_tuser;        // [0] printed, [3:1] status

   rpn_stack_evaluator DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // Predicted stack contents and the responses still owed by the block.
   logic signed [31:0] model_stack [DEPTH];
   int                 model_depth;
   resp_type           owed_resp [$];

   int  error_count;
   int  tokens_sent;
   int  resp_seen;
   int  idle_cycles;
   bit  quiet_phase;   // no idling in the final stretch
   bit  hold_rsp;      // receiver backpressure request
   int  status_hits [8];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on response %0d: %s got %h expected %h",
               resp_seen, what, got, want);
      error_count++;
   endtask

   // Q16.16 arithmetic of the evaluator, one token at a time.
   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
                                                  inout bit sat);
      if (v > Q_MAX) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < Q_MIN) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] pop_model(inout bit empty);
      if (model_depth == 0) begin
         empty = 1'b1;
         return 32'sd0;
      end
      model_depth--;
      return model_stack[model_depth];
   endfunction

   function automatic void push_model(input logic signed [31:0] v, inout bit full);
      if (model_depth >= DEPTH) begin
         full = 1'b1;
         return;
      end
      model_stack[model_depth] = v;
      model_depth++;
   endfunction

   function automatic resp_type evaluate_token(input logic [2:0] kind,
                                               input logic [31:0] operand);
      resp_type r;
      bit empty, sat, full, zdiv;
      logic signed [31:0] a, b;
      logic signed [63:0] wide;
      empty = 0; sat = 0; full = 0; zdiv = 0;
      r = '0;
      unique case (kind)
         TOK_NUM: push_model(operand, full);
         TOK_ADD, TOK_SUB, TOK_MUL: begin
            b = pop_model(empty);
            a = pop_model(empty);
            if (kind == TOK_ADD) wide = 64'(a) + 64'(b);
            else if (kind == TOK_SUB) wide = 64'(a) - 64'(b);
            else wide = (64'(a) * 64'(b)) >>> FRAC;   // arithmetic shift floors
            push_model(clamp32(wide, sat), full);
         end
         TOK_DIV, TOK_REM: begin
            b = pop_model(empty);
            if (b == 0) begin
               zdiv = 1'b1;
            end else begin
               a = pop_model(empty);
               if (kind == TOK_DIV) begin
                  wide = (64'(a) <<< FRAC) / 64'(b);   // truncates toward zero
                  push_model(clamp32(wide, sat), full);
               end else begin
                  wide = 64'(a) % 64'(b);
                  push_model(wide[31:0], full);
               end
            end
         end
         TOK_PRINT: begin
            r.value = pop_model(empty);
            r.printed = 1'b1;
         end
         default: r.status = ST_UNKNOWN;
      endcase
      if (kind != TOK_UNK) begin
         if (zdiv) r.status = ST_ZDIV;
         else if (full) r.status = ST_FULL;
         else if (empty) r.status = ST_EMPTY;
         else if (sat) r.status = ST_SAT;
         else r.status = ST_OK;
      end
      return r;
   endfunction

   // Random idle burst, skipped in the final stretch.
   // The request valid drops only when the sender actually idles.
   task automatic maybe_idle();
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   // Offers one token and waits for its transfer; the predicted response is
   // queued at the accepting edge so it precedes the block's response. The
   // task returns at the following falling edge with valid still high; the
   // next token or an idle stretch takes over from there.
   task automatic send_token(input logic [2:0] kind, input logic [31:0] operand,
                             input bit has_exp, input resp_type exp);
      resp_type r;
      r = evaluate_token(kind, operand);
      if (has_exp && r != exp)
         report_mismatch($sformatf("directed row %0d", tokens_sent), 64'(r), 64'(exp));
      req_tuser  <= kind;
      req_tdata  <= operand;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      owed_resp.push_back(r);
      tokens_sent++;
      @(negedge clock);
   endtask

   task automatic send_checked(input logic [2:0] kind, input logic [31:0] operand);
      send_token(kind, operand, 1'b0, '0);
      maybe_idle();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (owed_resp.size() != 0);
   endtask

   function automatic logic [31:0] random_value();
      unique case ($urandom_range(0, 5))
         0: return 32'h7fffffff - $urandom_range(0, 3);
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 8) << 16;          // small integers
         3: return -($urandom_range(0, 8) << 16);
         4: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // Receiver: random stalls, plus one long hold-off requested by the stimulus.
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Response checker and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      resp_type exp;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired with %0d responses outstanding",
                     owed_resp.size());
            $display("TB_ERROR");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (owed_resp.size() == 0) begin
               report_mismatch("unexpected response", 64'({rsp_tdata, rsp_tuser}), 64'(0));
            end else begin
               exp = owed_resp.pop_front();
               if (rsp_tdata !== exp.value)
                  report_mismatch("result_value", 64'(rsp_tdata), 64'(exp.value));
               if (rsp_tuser[0] !== exp.printed)
                  report_mismatch("printed", 64'(rsp_tuser[0]), 64'(exp.printed));
               if (rsp_tuser[3:1] !== exp.status)
                  report_mismatch("status", 64'(rsp_tuser[3:1]), 64'(exp.status));
               status_hits[exp.status]++;
            end
            resp_seen++;
         end
      end
   end

   stim_row_type directed [$];

   function automatic stim_row_type row(input logic [2:0] kind, input logic [31:0] v,
                                        input bit has_exp, input logic [31:0] ev,
                                        input logic pr, input logic [2:0] st);
      stim_row_type s;
      s.kind = kind;
      s.operand = v;
      s.has_exp = has_exp;
      s.exp = '{value: ev, printed: pr, status: st};
      return s;
   endfunction

   initial begin
      int k, depth_goal;
      logic [2:0] op;
      error_count = 0;
      model_depth = 0;
      quiet_phase = 0;
      hold_rsp = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty-stack cases, extremes, every token kind.
      directed = '{
         row(TOK_PRINT, 0, 1, 0, 1, ST_EMPTY),
         row(TOK_ADD, 0, 1, 0, 0, ST_EMPTY),
         row(TOK_PRINT, 32'hdeadbeef, 1, 0, 1, ST_OK),
         row(TOK_DIV, 0, 1, 0, 0, ST_ZDIV),
         row(TOK_REM, 0, 1, 0, 0, ST_ZDIV),
         row(TOK_UNK, 32'hffffffff, 1, 0, 0, ST_UNKNOWN),
         row(TOK_NUM, 32'h7fffffff, 1, 0, 0, ST_OK),
         row(TOK_NUM, 32'h00000001, 1, 0, 0, ST_OK),
         row(TOK_ADD, 0, 1, 0, 0, ST_SAT),
         row(TOK_PRINT, 0, 1, 32'h7fffffff, 1, ST_OK),
         row(TOK_NUM, 32'h80000000, 1, 0, 0, ST_OK),
         row(TOK_NUM, 32'h00000001, 1, 0, 0, ST_OK),
         row(TOK_SUB, 0, 1, 0, 0, ST_SAT),
         row(TOK_PRINT, 0, 1, 32'h80000000, 1, ST_OK),
         row(TOK_NUM, 32'hfffe8000, 0, 0, 0, ST_OK),     // -1.5
         row(TOK_NUM, 32'h00030000, 0, 0, 0, ST_OK),
         row(TOK_MUL, 0, 0, 0, 0, ST_OK),
         row(TOK_NUM, 32'h00020000, 0, 0, 0, ST_OK),
         row(TOK_DIV, 0, 0, 0, 0, ST_OK),
         row(TOK_NUM, 32'hfffd0000, 0, 0, 0, ST_OK),
         row(TOK_REM, 0, 0, 0, 0, ST_OK),
         row(TOK_NUM, 32'h00000000, 0, 0, 0, ST_OK),
         row(TOK_DIV, 0, 0, 0, 0, ST_OK),                 // divisor zero, left kept
         row(TOK_PRINT, 0, 0, 0, 0, ST_OK),
         row(TOK_PRINT, 0, 0, 0, 0, ST_OK)
      };
      foreach (directed[i])
         send_token(directed[i].kind, directed[i].operand,
                    directed[i].has_exp, directed[i].exp);

      // Fill past the top to hit the full-stack case, draining first.
      wait_drained();
      for (k = 0; k < DEPTH + 2; k++)
         send_checked(TOK_NUM, random_value());

      // Long receiver hold-off while tokens keep coming.
      hold_rsp = 1'b1;
      for (k = 0; k < 10; k++)
         send_checked(TOK_ADD, 0);
      wait_drained();

      // Random part: mostly well-formed expressions around a target depth.
      for (k = 0; k < N_RANDOM; k++) begin
         if (k == N_RANDOM - 120) quiet_phase = 1'b1;
         depth_goal = $urandom_range(0, 3) == 0 ? 0 : 3;
         if ($urandom_range(0, 15) == 0) begin
            op = 3'($urandom_range(0, 7));              // noise
         end else if (model_depth < depth_goal || $urandom_range(0, 2) == 0) begin
            op = TOK_NUM;
         end else begin
            op = 3'($urandom_range(1, 6));
         end
         send_checked(op, random_value());
         if (k == N_RANDOM / 2) wait_drained();
      end

      wait_drained();
      repeat (100) @(posedge clock);
      $display("%0d tokens, %0d responses; ok %0d full %0d empty %0d zdiv %0d",
               tokens_sent, resp_seen, status_hits[ST_OK], status_hits[ST_FULL],
               status_hits[ST_EMPTY], status_hits[ST_ZDIV]);
      $display("unknown %0d saturated %0d, %0d failures",
               status_hits[ST_UNKNOWN], status_hits[ST_SAT], error_count);
      if (error_count == 0 && owed_resp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/rse_pkg.sv
rtl/rse_stack.sv
rtl/rse_div.sv
rtl/rpn_stack_evaluator.sv
rtl/rse_checker.sv
dv/tb.sv
